// ===== hw/rtl/cbps_pkg.sv =====
// shared constants, types and codes of the cubic bezier point stepper
package cbps_pkg;

  // defaults of the top-level parameters
  localparam int DEF_STEPS      = 2048;
  localparam int DEF_COORD_BITS = 10;

  // datapath sized for the largest step count and coordinate width
  localparam int CHUNK_W    = 17;               // chunk of a stored weight
  localparam int NUM_CHUNKS = 3;
  localparam int TMP_W      = CHUNK_W * NUM_CHUNKS;
  localparam int OPA_W      = CHUNK_W;          // chunk, u or k
  localparam int OPB_W      = 18;               // u, k, p or 3*p
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int ACC_W      = 64;

  // scratch slots
  localparam int NUM_TMP = 6;
  localparam int SLOT_W  = 3;
  localparam logic [SLOT_W-1:0] T_U2 = 3'd0;    // u^2
  localparam logic [SLOT_W-1:0] T_K2 = 3'd1;    // k^2
  localparam logic [SLOT_W-1:0] T_V0 = 3'd2;    // u^3, k*u^2, k^2*u, k^3 follow

  // product count of the weight phase
  localparam int WGT_OPS = 10;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_X0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y1 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Y2 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_Y3 = 4'd7;

  typedef enum logic [1:0] {A_U, A_K, A_TMP} a_sel_t;
  typedef enum logic [2:0] {B_U, B_K, B_P0, B_P1X3, B_P2X3, B_P3} b_sel_t;

  // one multiply-accumulate step
  typedef struct packed {
    logic              en;
    logic              clr;
    logic [1:0]        sh;
    a_sel_t            a_sel;
    logic [SLOT_W-1:0] a_slot;
    logic [1:0]        a_chunk;
    b_sel_t            b_sel;
    logic              axis;
  } mac_op_t;

  // write-back of a finished accumulation, in the cycle after its last step
  typedef struct packed {
    logic              vld;
    logic              to_out;
    logic [SLOT_W-1:0] slot;
  } wb_t;

endpackage

// ===== hw/rtl/cbps_if.sv =====
// stream interfaces of the cubic bezier point stepper
interface cbps_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cbps_out_if import cbps_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// ===== hw/rtl/cbps_mac.sv =====
// shared 17x18 multiply-accumulate unit with chunk shift
module cbps_mac import cbps_pkg::*; (
  input  logic             clk,
  input  mac_op_t          op,
  input  logic [OPA_W-1:0] opa,
  input  logic [OPB_W-1:0] opb,
  output logic [ACC_W-1:0] acc
);

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;

  assign prod = opa * opb;

  always_comb begin
    case (op.sh)
      2'd0:    term = ACC_W'(prod);
      2'd1:    term = ACC_W'(prod) << CHUNK_W;
      2'd2:    term = ACC_W'(prod) << (2 * CHUNK_W);
      default: term = '0;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    if (op.en) begin
      acc_nxt = op.clr ? term : acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== hw/rtl/cbps_opnd.sv =====
// scratch weights and operand selection for the shared multiplier
module cbps_opnd import cbps_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                       clk,
  input  mac_op_t                    op,
  input  wb_t                        wb,
  input  logic [ACC_W-1:0]           acc,
  input  logic [OPA_W-1:0]           k_op,
  input  logic [OPA_W-1:0]           u_op,
  input  logic [3:0][COORD_BITS-1:0] ctrl_x,
  input  logic [3:0][COORD_BITS-1:0] ctrl_y,
  output logic [OPA_W-1:0]           opa,
  output logic [OPB_W-1:0]           opb
);

  logic [TMP_W-1:0]           tmp_r [NUM_TMP];
  logic [TMP_W-1:0]           tmp_rd;
  logic [OPA_W-1:0]           chunk;
  logic [3:0][COORD_BITS-1:0] pts;

  always_ff @(posedge clk) begin
    if (wb.vld && !wb.to_out) begin
      tmp_r[wb.slot] <= acc[TMP_W-1:0];
    end
  end

  assign tmp_rd = tmp_r[op.a_slot];

  always_comb begin
    case (op.a_chunk)
      2'd0:    chunk = tmp_rd[0 +: CHUNK_W];
      2'd1:    chunk = tmp_rd[CHUNK_W +: CHUNK_W];
      2'd2:    chunk = tmp_rd[2*CHUNK_W +: CHUNK_W];
      default: chunk = '0;
    endcase
  end

  always_comb begin
    case (op.a_sel)
      A_U:     opa = u_op;
      A_K:     opa = k_op;
      A_TMP:   opa = chunk;
      default: opa = '0;
    endcase
  end

  assign pts = op.axis ? ctrl_y : ctrl_x;

  // inner points carry the binomial factor 3
  always_comb begin
    case (op.b_sel)
      B_U:     opb = OPB_W'(u_op);
      B_K:     opb = OPB_W'(k_op);
      B_P0:    opb = OPB_W'(pts[0]);
      B_P1X3:  opb = (OPB_W'(pts[1]) << 1) + OPB_W'(pts[1]);
      B_P2X3:  opb = (OPB_W'(pts[2]) << 1) + OPB_W'(pts[2]);
      B_P3:    opb = OPB_W'(pts[3]);
      default: opb = '0;
    endcase
  end

endmodule

// ===== hw/rtl/cbps_ctl.sv =====
// sequencer: handshake, step counter, micro-step decode and result register
module cbps_ctl import cbps_pkg::*; #(
  parameter int STEPS      = DEF_STEPS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_restart,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  out_last,
  input  logic [ACC_W-1:0]      acc,
  output mac_op_t               op,
  output wb_t                   wb,
  output logic [OPA_W-1:0]      k_op,
  output logic [OPA_W-1:0]      u_op
);

  localparam int SB      = $clog2(STEPS);
  localparam int UW      = SB + 1;
  localparam int RES_LSB = 3 * SB;

  typedef enum logic [2:0] {S_IDLE, S_WGT, S_PNT, S_FLUSH, S_PUSH} state_t;

  state_t                state_r, state_nxt;
  logic [SB-1:0]         step_r, step_nxt;
  logic [SB-1:0]         k_r, k_nxt;
  logic [UW-1:0]         u_r, u_nxt;
  logic                  last_r, last_nxt;
  logic [3:0]            j_r, j_nxt;
  logic [1:0]            w_r, w_nxt;
  logic [1:0]            c_r, c_nxt;
  logic                  axis_r, axis_nxt;
  wb_t                   wb_r, wb_nxt;
  logic [COORD_BITS-1:0] res_x_r, res_x_nxt;
  logic [COORD_BITS-1:0] res_y_r, res_y_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0] out_y_r, out_y_nxt;
  logic                  out_last_r, out_last_nxt;

  mac_op_t               op_c;
  logic                  op_end;
  logic [SLOT_W-1:0]     dest;
  logic [2:0]            m;
  logic [SB-1:0]         k_sel;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    u_nxt         = u_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    c_nxt         = c_r;
    axis_nxt      = axis_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;

    op_c         = '0;
    op_c.a_sel   = A_U;
    op_c.b_sel   = B_U;
    op_end       = 1'b0;
    dest         = '0;
    m            = 3'(j_r - 4'd2);
    k_sel        = in_restart ? '0 : step_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt     = k_sel;
          u_nxt     = UW'(STEPS) - UW'(k_sel);
          last_nxt  = &k_sel;
          step_nxt  = k_sel + 1'b1;
          j_nxt     = '0;
          state_nxt = S_WGT;
        end
      end
      S_WGT: begin
        op_c.en = 1'b1;
        if (j_r == 4'd0) begin
          op_c.clr   = 1'b1;
          op_c.a_sel = A_U;
          op_c.b_sel = B_U;
          op_end     = 1'b1;
          dest       = T_U2;
        end else if (j_r == 4'd1) begin
          op_c.clr   = 1'b1;
          op_c.a_sel = A_K;
          op_c.b_sel = B_K;
          op_end     = 1'b1;
          dest       = T_K2;
        end else begin
          // two chunks of u^2 or k^2 times u or k
          op_c.clr     = !m[0];
          op_c.sh      = {1'b0, m[0]};
          op_c.a_sel   = A_TMP;
          op_c.a_slot  = m[2] ? T_K2 : T_U2;
          op_c.a_chunk = {1'b0, m[0]};
          op_c.b_sel   = m[1] ? B_K : B_U;
          op_end       = m[0];
          dest         = T_V0 + {1'b0, m[2:1]};
        end
        if (j_r == 4'(WGT_OPS - 1)) begin
          w_nxt     = '0;
          c_nxt     = '0;
          axis_nxt  = 1'b0;
          state_nxt = S_PNT;
        end else begin
          j_nxt = j_r + 4'd1;
        end
      end
      S_PNT: begin
        op_c.en      = 1'b1;
        op_c.clr     = (w_r == 2'd0) && (c_r == 2'd0);
        op_c.sh      = c_r;
        op_c.a_sel   = A_TMP;
        op_c.a_slot  = T_V0 + {1'b0, w_r};
        op_c.a_chunk = c_r;
        op_c.axis    = axis_r;
        case (w_r)
          2'd0:    op_c.b_sel = B_P0;
          2'd1:    op_c.b_sel = B_P1X3;
          2'd2:    op_c.b_sel = B_P2X3;
          default: op_c.b_sel = B_P3;
        endcase
        dest = {2'b00, axis_r};
        if (c_r == 2'(NUM_CHUNKS - 1)) begin
          c_nxt = '0;
          if (w_r == 2'd3) begin
            op_end   = 1'b1;
            w_nxt    = '0;
            axis_nxt = 1'b1;
            if (axis_r) begin
              state_nxt = S_FLUSH;
            end
          end else begin
            w_nxt = w_r + 2'd1;
          end
        end else begin
          c_nxt = c_r + 2'd1;
        end
      end
      S_FLUSH: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // sum / STEPS^3 is the upper part of the accumulator
    if (wb_r.vld && wb_r.to_out) begin
      if (wb_r.slot[0]) begin
        res_y_nxt = acc[RES_LSB +: COORD_BITS];
      end else begin
        res_x_nxt = acc[RES_LSB +: COORD_BITS];
      end
    end

    wb_nxt.vld    = op_end;
    wb_nxt.to_out = (state_r == S_PNT);
    wb_nxt.slot   = dest;
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    u_r        <= u_nxt;
    last_r     <= last_nxt;
    j_r        <= j_nxt;
    w_r        <= w_nxt;
    c_r        <= c_nxt;
    axis_r     <= axis_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
    wb_r.to_out <= wb_nxt.to_out;
    wb_r.slot   <= wb_nxt.slot;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      wb_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      wb_r.vld    <= wb_nxt.vld;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;
  assign op        = op_c;
  assign wb        = wb_r;
  assign k_op      = OPA_W'(k_r);
  assign u_op      = OPA_W'(u_r);

endmodule

// ===== hw/rtl/cubic_bezier_point_stepper_unit.sv =====
// top level of the cubic bezier point stepper
//
//  channel   dir  handshake             payload
//  in_if     in   valid / ready         restart
//  out_if    out  valid / ready         point_x, point_y, last_point
//  cfg_*     in   cfg_we (no wait)      cfg_idx, cfg_wdata
//
// a transaction is taken only in the idle state, so a new one waits until the
// result of the last has been pushed; every product runs through the one 17x18
// multiply-accumulate unit, which runs 10 weight products and 24 point products
// rst_n is synchronous: the step counter returns to zero, control points to 0
// a held result on out_if does not block input; only the final push of the
// next result waits until the output register is free
module cubic_bezier_point_stepper_unit import cbps_pkg::*; #(
  parameter int STEPS      = DEF_STEPS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  cbps_in_if.sink               in_if,
  cbps_out_if.source            out_if
);

  // control points, index 0 is the start point and 3 the end point
  logic [3:0][COORD_BITS-1:0] ctrl_x_r;
  logic [3:0][COORD_BITS-1:0] ctrl_y_r;

  mac_op_t          op;
  wb_t              wb;
  logic [ACC_W-1:0] acc;
  logic [OPA_W-1:0] k_op;
  logic [OPA_W-1:0] u_op;
  logic [OPA_W-1:0] opa;
  logic [OPB_W-1:0] opb;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_x_r <= '0;
      ctrl_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_X0:  ctrl_x_r[0] <= cfg_wdata;
        CFG_X1:  ctrl_x_r[1] <= cfg_wdata;
        CFG_X2:  ctrl_x_r[2] <= cfg_wdata;
        CFG_X3:  ctrl_x_r[3] <= cfg_wdata;
        CFG_Y0:  ctrl_y_r[0] <= cfg_wdata;
        CFG_Y1:  ctrl_y_r[1] <= cfg_wdata;
        CFG_Y2:  ctrl_y_r[2] <= cfg_wdata;
        CFG_Y3:  ctrl_y_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: takes the transaction, latches k and u = STEPS - k, then walks
  // the weight products (u^2, k^2, u^3, k*u^2, k^2*u, k^3) and the four
  // weighted control points per axis
  cbps_ctl #(
    .STEPS      (STEPS),
    .COORD_BITS (COORD_BITS)
  ) u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_restart (in_if.restart),
    .in_ready   (in_if.ready),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_x      (out_if.point_x),
    .out_y      (out_if.point_y),
    .out_last   (out_if.last_point),
    .acc        (acc),
    .op         (op),
    .wb         (wb),
    .k_op       (k_op),
    .u_op       (u_op)
  );

  // weights held as three 17-bit chunks, picked one chunk per product
  cbps_opnd #(
    .COORD_BITS (COORD_BITS)
  ) u_opnd (
    .clk    (clk),
    .op     (op),
    .wb     (wb),
    .acc    (acc),
    .k_op   (k_op),
    .u_op   (u_op),
    .ctrl_x (ctrl_x_r),
    .ctrl_y (ctrl_y_r),
    .opa    (opa),
    .opb    (opb)
  );

  // exact 64-bit Bernstein sum; never exceeds max coordinate * STEPS^3
  cbps_mac u_mac (
    .clk (clk),
    .op  (op),
    .opa (opa),
    .opb (opb),
    .acc (acc)
  );

endmodule

// ===== hw/rtl/cbps_chk.sv =====
// port-level assertions of the cubic bezier point stepper
module cbps_chk import cbps_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] point_x,
  input logic [COORD_BITS-1:0] point_y,
  input logic                  last_point
);

  // the unit is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // a new result only appears at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a busy period before it");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(point_x) && $stable(point_y) && $stable(last_point)))
    else $error("result payload changed while stalled");

endmodule

bind cubic_bezier_point_stepper_unit cbps_chk #(
  .COORD_BITS (COORD_BITS)
) u_cbps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .point_x    (out_if.point_x),
  .point_y    (out_if.point_y),
  .last_point (out_if.last_point)
);

// ===== bench/tb_cubic_bezier_point_stepper_unit.sv =====
// testbench of the cubic bezier point stepper: directed table, random phases, short sweep
module tb_cubic_bezier_point_stepper_unit import cbps_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS      = DEF_STEPS;
  localparam int COORD_BITS = DEF_COORD_BITS;
  localparam int K_W        = $clog2(STEPS);

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_PAST_END = CFG_Y3 + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX  = {CFG_IDX_W{1'b1}};

  localparam int IDLE_PCT       = 36;       // idle cycles per hundred on each side
  localparam int RESTART_PCT    = 6;        // restart ticks per hundred in random phases
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_TICKS    = 150;
  localparam int SWEEP_TICKS    = 40;       // plain steps after one restart
  localparam int LATENCY_CYCLES = 40;       // wait at the end for any stray point
  localparam int CYCLE_LIMIT    = 1000000;

  // one expected point of the curve
  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } curve_point_t;

  // directed stimulus rows: a tick on the input channel or a register write
  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [COORD_BITS-1:0] wdata;
    logic                  restart;
    bit                    typed;   // expected point given in the row itself
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic                  elast;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [COORD_BITS-1:0] cfg_wdata;

  cbps_in_if                                  in_ch();
  cbps_out_if #(.COORD_BITS(COORD_BITS))      out_ch();

  cubic_bezier_point_stepper_unit #(
    .STEPS     (STEPS),
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // shadow of the control points and the step counter
  logic [COORD_BITS-1:0] ctl_x [4];
  logic [COORD_BITS-1:0] ctl_y [4];
  logic [K_W-1:0]        next_k;

  curve_point_t pending_points[$];
  int           err_count;
  int           cycle_count;
  bit           quiet;          // no idling on either side while set

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // exact bernstein sum at t = k / STEPS, floored to a whole pixel
  function automatic logic [COORD_BITS-1:0] bezier_coord(
    input logic [K_W-1:0] k,
    input logic [COORD_BITS-1:0] p0, p1, p2, p3
  );
    longint unsigned s, kk, u, w0, w1, w2, w3, sum;
    s   = STEPS;
    kk  = k;
    u   = s - kk;
    w0  = u * u * u;
    w1  = 3 * kk * u * u;
    w2  = 3 * kk * kk * u;
    w3  = kk * kk * kk;
    sum = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
    return COORD_BITS'(sum / (s * s * s));
  endfunction

  // point the block should give for one accepted tick, counter advanced
  function automatic curve_point_t next_curve_point(input logic restart);
    curve_point_t  pt;
    logic [K_W-1:0] k;
    k       = restart ? '0 : next_k;
    pt.x    = bezier_coord(k, ctl_x[0], ctl_x[1], ctl_x[2], ctl_x[3]);
    pt.y    = bezier_coord(k, ctl_y[0], ctl_y[1], ctl_y[2], ctl_y[3]);
    pt.last = (k == K_W'(STEPS - 1));
    next_k  = k + 1'b1;   // wraps at the end of the curve
    return pt;
  endfunction

  function automatic bit take_gap();
    return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, checked at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    curve_point_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("point transaction with nothing expected: x %0d y %0d last %0d",
               out_ch.point_x, out_ch.point_y, out_ch.last_point);
        err_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_ch.point_x !== want.x) begin
          $error("point_x expected %0d got %0d", want.x, out_ch.point_x);
          err_count++;
        end
        if (out_ch.point_y !== want.y) begin
          $error("point_y expected %0d got %0d", want.y, out_ch.point_y);
          err_count++;
        end
        if (out_ch.last_point !== want.last) begin
          $error("last_point expected %0d got %0d", want.last, out_ch.last_point);
          err_count++;
        end
      end
    end
  end

  // watchdog, counts every cycle from time zero
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one tick transaction; valid is left high so back-to-back ticks need no gap
  task automatic send_tick(input logic restart, output curve_point_t pt);
    @(negedge clk);
    while (take_gap()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pt = next_curve_point(restart);
  endtask

  // tick with the predicted point queued
  task automatic tick_predicted(input logic restart);
    curve_point_t pt;
    send_tick(restart, pt);
    pending_points.push_back(pt);
  endtask

  // drop valid, then hold off until every queued point has come back
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // single-cycle register write, only called with the block idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COORD_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_X0: ctl_x[0] = data;
      CFG_X1: ctl_x[1] = data;
      CFG_X2: ctl_x[2] = data;
      CFG_X3: ctl_x[3] = data;
      CFG_Y0: ctl_y[0] = data;
      CFG_Y1: ctl_y[1] = data;
      CFG_Y2: ctl_y[2] = data;
      CFG_Y3: ctl_y[3] = data;
      default: ;   // past the list, the block drops it
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // pick a coordinate: one of the extremes or anything in range
  function automatic logic [COORD_BITS-1:0] pick_coord(input int mode);
    case (mode)
      1:       return COORD_MAX;
      2:       return '0;
      default: return COORD_BITS'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  // write all eight control registers for one random phase or the sweep
  task automatic load_curve(input int phase);
    logic [CFG_IDX_W-1:0] idx;
    int                   mode;
    for (int i = 0; i < 8; i++) begin
      idx = CFG_X0 + CFG_IDX_W'(i);
      case (phase)
        1:       mode = 1;                       // every point at the far corner
        2:       mode = (i % 2 == 0) ? 2 : 1;    // alternating extremes
        5:       mode = $urandom_range(0, 2);    // mix of extremes and random
        default: mode = 0;
      endcase
      cfg_write(idx, pick_coord(mode));
    end
    // stray write past the register list now and then
    if ($urandom_range(0, 1) == 1)
      cfg_write(CFG_IDX_W'($urandom_range(CFG_PAST_END, CFG_IDX_MAX)),
                COORD_BITS'($urandom_range(0, COORD_MAX)));
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  //   ticks on the reset curve give the origin, a curve with every point at
  //   the far corner gives the corner at every step, writes past the list
  //   leave it unchanged, restart returns to the start control point
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[] = '{
    '{ROW_TICK, CFG_X0,       '0,        1'b0, 1'b1, '0,        '0,        1'b0},
    '{ROW_TICK, CFG_X0,       '0,        1'b1, 1'b1, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_X0,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_X1,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_X2,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_X3,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_Y0,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_Y1,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_Y2,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_Y3,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_TICK, CFG_X0,       '0,        1'b1, 1'b1, COORD_MAX, COORD_MAX, 1'b0},
    '{ROW_TICK, CFG_X0,       '0,        1'b0, 1'b1, COORD_MAX, COORD_MAX, 1'b0},
    '{ROW_CFG,  CFG_PAST_END, '0,        1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_IDX_MAX,  '0,        1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_TICK, CFG_X0,       '0,        1'b0, 1'b1, COORD_MAX, COORD_MAX, 1'b0},
    '{ROW_CFG,  CFG_X0,       '0,        1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_X1,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_X2,       '0,        1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_X3,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_Y0,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_Y1,       '0,        1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_Y2,       COORD_MAX, 1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_CFG,  CFG_Y3,       '0,        1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_TICK, CFG_X0,       '0,        1'b1, 1'b1, '0,        COORD_MAX, 1'b0},
    '{ROW_TICK, CFG_X0,       '0,        1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_TICK, CFG_X0,       '0,        1'b0, 1'b0, '0,        '0,        1'b0},
    '{ROW_TICK, CFG_X0,       '0,        1'b1, 1'b0, '0,        '0,        1'b0}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    curve_point_t pt;
    int           pause_at;

    // every input known from time zero
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_X0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    quiet         = 1'b0;
    err_count     = 0;
    cycle_count   = 0;
    next_k        = '0;
    for (int i = 0; i < 4; i++) begin
      ctl_x[i] = '0;
      ctl_y[i] = '0;
    end

    // hold synchronous reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_rows[r].idx, dir_rows[r].wdata);
      end else begin
        send_tick(dir_rows[r].restart, pt);
        if (dir_rows[r].typed) begin
          pt.x    = dir_rows[r].ex;
          pt.y    = dir_rows[r].ey;
          pt.last = dir_rows[r].elast;
        end
        pending_points.push_back(pt);
      end
    end

    // random phases, each on a fresh curve
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      load_curve(p);
      quiet    = (p == 3);   // one long stretch without idling
      pause_at = (p == 4) ? $urandom_range(20, PHASE_TICKS - 20) : -1;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // sender holds off once until every point has come back
        if (n == pause_at)
          settle();
        tick_predicted((n == 0) || ($urandom_range(0, 99) < RESTART_PCT));
      end
    end
    quiet = 1'b0;

    // short sweep: one restart then a run of plain steps
    settle();
    load_curve(0);
    tick_predicted(1'b1);
    for (int n = 0; n < SWEEP_TICKS; n++)
      tick_predicted(1'b0);

    // wind down
    settle();
    repeat (LATENCY_CYCLES) @(posedge clk);
    if (pending_points.size() != 0) begin
      $error("%0d points still expected at the end", pending_points.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
